// ----- design/nstc_pkg.sv -----
// ---------------------------------------------------------------------------
// Nested span timer capture package
// Shared widths, request codes, operation and error codes, and the structs
// passed between the front end and the back end of the span profiler.
// ---------------------------------------------------------------------------
package nstc_pkg;

   // Field widths of the request and response words.
   localparam int REQ_TYPE_W      = 2;
   localparam int SPAN_ID_W       = 5;
   localparam int TIME_W          = 64;
   localparam int READ_INDEX_W    = 8;
   localparam int RD_DEPTH_W      = 4;
   localparam int CAPTURE_COUNT_W = 9;
   localparam int ACTIVE_DEPTH_W  = 5;
   localparam int ERROR_W         = 2;

   // Default sizes of the nesting stack and the capture memory.
   localparam int STACK_DEPTH_DEF     = 16;
   localparam int CAPTURE_ENTRIES_DEF = 256;

   // Depth of the command queue between the front end and the back end.
   localparam int QUEUE_DEPTH = 2;

   // Request type codes as they arrive on the port.
   localparam logic [REQ_TYPE_W-1:0] REQ_FRAME = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_BEGIN = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_END   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 2'd3;

   typedef enum logic [1:0] {
      OP_FRAME,
      OP_BEGIN,
      OP_END,
      OP_READ
   } op_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_NONE,
      ERR_FULL,
      ERR_EMPTY,
      ERR_MISMATCH
   } error_type;

   typedef enum logic {
      BACK_RUN,
      BACK_READ
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic [SPAN_ID_W-1:0]     span_id;
      logic [TIME_W-1:0]        now_ns;
      logic [READ_INDEX_W-1:0]  read_index;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_head_type;

   typedef struct packed {
      logic [SPAN_ID_W-1:0]  span_id;
      logic [RD_DEPTH_W-1:0] depth;
      logic [TIME_W-1:0]     start_ns;
      logic [TIME_W-1:0]     duration_ns;
   } cap_entry_type;

endpackage

// ----- design/nstc_front.sv -----
// ---------------------------------------------------------------------------
// Span profiler front end
// Accepts request words, decodes the request type into an operation and
// holds the words in a short queue until the back end takes them.
// ---------------------------------------------------------------------------
module nstc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [nstc_pkg::REQ_TYPE_W-1:0]     req_type,
   input  logic [nstc_pkg::SPAN_ID_W-1:0]      req_span_id,
   input  logic [nstc_pkg::TIME_W-1:0]         req_now_ns,
   input  logic [nstc_pkg::READ_INDEX_W-1:0]   req_read_index,
   output nstc_pkg::queue_head_type            head,
   input  logic                                pop
);

   localparam int QD     = nstc_pkg::QUEUE_DEPTH;
   localparam int QPTR_W = (QD > 1) ? $clog2(QD) : 1;
   localparam int QCNT_W = $clog2(QD + 1);

   nstc_pkg::queue_entry_type queue_ff [QD];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;
   logic              accept;
   nstc_pkg::queue_entry_type word_in;

   assign busy   = (fill_ff == QCNT_W'(QD));
   assign accept = start && !busy;

   // Decode the request type into the back end's operation.
   always_comb begin
      word_in.span_id    = req_span_id;
      word_in.now_ns     = req_now_ns;
      word_in.read_index = req_read_index;
      case (req_type)
         nstc_pkg::REQ_FRAME: word_in.op = nstc_pkg::OP_FRAME;
         nstc_pkg::REQ_BEGIN: word_in.op = nstc_pkg::OP_BEGIN;
         nstc_pkg::REQ_END:   word_in.op = nstc_pkg::OP_END;
         default:             word_in.op = nstc_pkg::OP_READ;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !accept) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= word_in;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

endmodule

// ----- design/nstc_back.sv -----
// ---------------------------------------------------------------------------
// Span profiler back end
// Executes queued operations against the nesting stack and the capture
// memory, and drives one registered response word per operation.
// ---------------------------------------------------------------------------
module nstc_back #(
   parameter int STACK_DEPTH     = nstc_pkg::STACK_DEPTH_DEF,
   parameter int CAPTURE_ENTRIES = nstc_pkg::CAPTURE_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  nstc_pkg::queue_head_type              head,
   output logic                                  pop,
   output logic                                  rsp_valid,
   output logic                                  rsp_rd_valid,
   output logic [nstc_pkg::SPAN_ID_W-1:0]        rsp_rd_span_id,
   output logic [nstc_pkg::RD_DEPTH_W-1:0]       rsp_rd_depth,
   output logic [nstc_pkg::TIME_W-1:0]           rsp_rd_start_ns,
   output logic [nstc_pkg::TIME_W-1:0]           rsp_rd_duration_ns,
   output logic [nstc_pkg::CAPTURE_COUNT_W-1:0]  rsp_capture_count,
   output logic                                  rsp_overflowed,
   output logic [nstc_pkg::ACTIVE_DEPTH_W-1:0]   rsp_active_depth,
   output logic [nstc_pkg::ERROR_W-1:0]          rsp_error_code
);

   localparam int SP_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SP_CW  = $clog2(STACK_DEPTH + 1);
   localparam int CAP_AW = (CAPTURE_ENTRIES > 1) ? $clog2(CAPTURE_ENTRIES) : 1;
   localparam int CAP_CW = $clog2(CAPTURE_ENTRIES + 1);
   localparam int CMP_W  = (CAP_CW > nstc_pkg::READ_INDEX_W) ? CAP_CW
                                                            : nstc_pkg::READ_INDEX_W;
   localparam int TW     = nstc_pkg::TIME_W;

   // Nesting stack and capture memory.
   logic [nstc_pkg::SPAN_ID_W-1:0] open_ids_ff    [STACK_DEPTH];
   logic [TW-1:0]                  open_starts_ff [STACK_DEPTH];
   nstc_pkg::cap_entry_type        cap_mem        [CAPTURE_ENTRIES];

   nstc_pkg::back_state_type state_ff, state_in;
   logic [SP_CW-1:0]  open_count_ff, open_count_in;
   logic [CAP_CW-1:0] captured_ff, captured_in;
   logic              overflow_ff, overflow_in;

   logic                    push_en;
   logic [SP_AW-1:0]        push_idx;
   logic [SP_AW-1:0]        top_idx;
   logic                    cap_we;
   logic [CAP_AW-1:0]       cap_waddr;
   nstc_pkg::cap_entry_type cap_wdata;
   logic                    rd_en;
   logic [CAP_AW-1:0]       rd_addr;
   nstc_pkg::cap_entry_type cap_rdata_ff;
   logic                    rd_hit_ff, rd_hit_in;
   logic [CMP_W-1:0]        idx_ext;
   logic [TW:0]             diff;
   logic [TW-1:0]           top_start;
   logic [nstc_pkg::SPAN_ID_W-1:0] top_id;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_rd_valid_ff, rsp_rd_valid_in;
   nstc_pkg::cap_entry_type              rsp_rd_ff, rsp_rd_in;
   logic [nstc_pkg::CAPTURE_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                                 rsp_ovf_ff, rsp_ovf_in;
   logic [nstc_pkg::ACTIVE_DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   nstc_pkg::error_type                  rsp_err_ff, rsp_err_in;

   assign push_idx  = open_count_ff[SP_AW-1:0];
   assign top_idx   = SP_AW'(open_count_ff - SP_CW'(1));
   assign top_id    = open_ids_ff[top_idx];
   assign top_start = open_starts_ff[top_idx];
   assign diff      = {1'b0, head.entry.now_ns} - {1'b0, top_start};
   assign idx_ext   = CMP_W'(head.entry.read_index);
   assign rd_addr   = CAP_AW'(head.entry.read_index);
   assign cap_waddr = CAP_AW'(captured_ff);

   always_comb begin
      state_in        = state_ff;
      open_count_in   = open_count_ff;
      captured_in     = captured_ff;
      overflow_in     = overflow_ff;
      pop             = 1'b0;
      push_en         = 1'b0;
      cap_we          = 1'b0;
      rd_en           = 1'b0;
      rd_hit_in       = rd_hit_ff;
      rsp_valid_in    = 1'b0;
      rsp_rd_valid_in = 1'b0;
      rsp_rd_in       = '0;
      rsp_err_in      = nstc_pkg::ERR_NONE;
      cap_wdata.span_id     = top_id;
      cap_wdata.depth       = nstc_pkg::RD_DEPTH_W'(open_count_ff - SP_CW'(1));
      cap_wdata.start_ns    = top_start;
      cap_wdata.duration_ns = diff[TW] ? '0 : diff[TW-1:0];

      case (state_ff)
         nstc_pkg::BACK_RUN: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.entry.op)
                  nstc_pkg::OP_FRAME: begin
                     captured_in  = '0;
                     overflow_in  = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  nstc_pkg::OP_BEGIN: begin
                     rsp_valid_in = 1'b1;
                     if (open_count_ff == SP_CW'(STACK_DEPTH)) begin
                        rsp_err_in = nstc_pkg::ERR_FULL;
                     end else begin
                        push_en       = 1'b1;
                        open_count_in = open_count_ff + SP_CW'(1);
                     end
                  end
                  nstc_pkg::OP_END: begin
                     rsp_valid_in = 1'b1;
                     if (open_count_ff == '0) begin
                        rsp_err_in = nstc_pkg::ERR_EMPTY;
                     end else begin
                        open_count_in = open_count_ff - SP_CW'(1);
                        if (top_id != head.entry.span_id) begin
                           rsp_err_in = nstc_pkg::ERR_MISMATCH;
                        end
                        if (captured_ff < CAP_CW'(CAPTURE_ENTRIES)) begin
                           cap_we      = 1'b1;
                           captured_in = captured_ff + CAP_CW'(1);
                        end else begin
                           overflow_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                     rd_en     = 1'b1;
                     rd_hit_in = (idx_ext < CMP_W'(captured_ff)) &&
                                 (idx_ext < CMP_W'(CAPTURE_ENTRIES));
                     state_in  = nstc_pkg::BACK_READ;
                  end
               endcase
            end
         end
         nstc_pkg::BACK_READ: begin
            // Captured data is back from the memory; the read's status is
            // unchanged since nothing else ran in between.
            rsp_valid_in    = 1'b1;
            rsp_rd_valid_in = rd_hit_ff;
            rsp_rd_in       = rd_hit_ff ? cap_rdata_ff : '0;
            state_in        = nstc_pkg::BACK_RUN;
         end
         default: begin
            state_in = nstc_pkg::BACK_RUN;
         end
      endcase

      rsp_count_in = nstc_pkg::CAPTURE_COUNT_W'(captured_in);
      rsp_ovf_in   = overflow_in;
      rsp_depth_in = nstc_pkg::ACTIVE_DEPTH_W'(open_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= nstc_pkg::BACK_RUN;
         open_count_ff <= '0;
         captured_ff   <= '0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         open_count_ff <= open_count_in;
         captured_ff   <= captured_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_hit_ff <= rd_hit_in;
      if (rsp_valid_in) begin
         rsp_rd_valid_ff <= rsp_rd_valid_in;
         rsp_rd_ff       <= rsp_rd_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_ovf_ff      <= rsp_ovf_in;
         rsp_depth_ff    <= rsp_depth_in;
         rsp_err_ff      <= rsp_err_in;
      end
      if (push_en) begin
         open_ids_ff[push_idx]    <= head.entry.span_id;
         open_starts_ff[push_idx] <= head.entry.now_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (cap_we) begin
         cap_mem[cap_waddr] <= cap_wdata;
      end
      if (rd_en) begin
         cap_rdata_ff <= cap_mem[rd_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rd_valid       = rsp_rd_valid_ff;
   assign rsp_rd_span_id     = rsp_rd_ff.span_id;
   assign rsp_rd_depth       = rsp_rd_ff.depth;
   assign rsp_rd_start_ns    = rsp_rd_ff.start_ns;
   assign rsp_rd_duration_ns = rsp_rd_ff.duration_ns;
   assign rsp_capture_count  = rsp_count_ff;
   assign rsp_overflowed     = rsp_ovf_ff;
   assign rsp_active_depth   = rsp_depth_ff;
   assign rsp_error_code     = rsp_err_ff;

endmodule

// ----- design/nested_span_timer_capture_top.sv -----
// ---------------------------------------------------------------------------
// Nested span timer capture
// Hardware span profiler with a nesting stack and a capture memory.
// ---------------------------------------------------------------------------
// Usage: a request word (req_type, req_span_id, req_now_ns, req_read_index)
// is taken at a rising edge where start is high and busy is low. A frame
// start clears the capture count and the overflow flag, a span begin pushes
// its id and timestamp, a span end pops the top span and records it in the
// capture memory while it has room, and a read returns one captured entry
// by index. Every request word gives exactly one response word, shown for
// one cycle with rsp_valid high; the receiver cannot hold it off, so the
// response side never stalls.
// Path: a frame, begin or end word passes through the queue and then the
// registered response word; a read also passes through the registered
// capture memory read and the back end's read state. The back end takes
// one frame, begin or end word per cycle while no read is in progress; a
// read holds it in its read state, so the next word waits in the queue. A
// two-word queue sits in front, and busy is high only while it is full.
// Reset empties the stack, clears the capture count and the overflow flag
// and drops any queued words. There is no clearing pass: capture entries
// are only read below the count, so no stale entry is ever returned.
// ---------------------------------------------------------------------------
module nested_span_timer_capture_top #(
   parameter int STACK_DEPTH     = nstc_pkg::STACK_DEPTH_DEF,
   parameter int CAPTURE_ENTRIES = nstc_pkg::CAPTURE_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [nstc_pkg::REQ_TYPE_W-1:0]       req_type,
   input  logic [nstc_pkg::SPAN_ID_W-1:0]        req_span_id,
   input  logic [nstc_pkg::TIME_W-1:0]           req_now_ns,
   input  logic [nstc_pkg::READ_INDEX_W-1:0]     req_read_index,
   output logic                                  rsp_valid,
   output logic                                  rsp_rd_valid,
   output logic [nstc_pkg::SPAN_ID_W-1:0]        rsp_rd_span_id,
   output logic [nstc_pkg::RD_DEPTH_W-1:0]       rsp_rd_depth,
   output logic [nstc_pkg::TIME_W-1:0]           rsp_rd_start_ns,
   output logic [nstc_pkg::TIME_W-1:0]           rsp_rd_duration_ns,
   output logic [nstc_pkg::CAPTURE_COUNT_W-1:0]  rsp_capture_count,
   output logic                                  rsp_overflowed,
   output logic [nstc_pkg::ACTIVE_DEPTH_W-1:0]   rsp_active_depth,
   output logic [nstc_pkg::ERROR_W-1:0]          rsp_error_code
);

   // Head of the queue as the back end sees it, and the back end's pop.
   nstc_pkg::queue_head_type head;
   logic                     pop;

   // The front end decodes each accepted word and queues it.
   nstc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_span_id    (req_span_id),
      .req_now_ns     (req_now_ns),
      .req_read_index (req_read_index),
      .head           (head),
      .pop            (pop)
   );

   // The back end owns the stack, the capture memory and the response.
   nstc_back #(
      .STACK_DEPTH     (STACK_DEPTH),
      .CAPTURE_ENTRIES (CAPTURE_ENTRIES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_rd_valid       (rsp_rd_valid),
      .rsp_rd_span_id     (rsp_rd_span_id),
      .rsp_rd_depth       (rsp_rd_depth),
      .rsp_rd_start_ns    (rsp_rd_start_ns),
      .rsp_rd_duration_ns (rsp_rd_duration_ns),
      .rsp_capture_count  (rsp_capture_count),
      .rsp_overflowed     (rsp_overflowed),
      .rsp_active_depth   (rsp_active_depth),
      .rsp_error_code     (rsp_error_code)
   );

endmodule

// ----- dv/nstc_capture_monitor.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Span capture monitor
// Watches the request and response channels of the span profiler, keeps its
// own copy of the nesting stack and capture memory, forecasts the response
// to every accepted word and compares each response field by field.
// ---------------------------------------------------------------------------
module nstc_capture_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [nstc_pkg::REQ_TYPE_W-1:0]      req_type,
   input  logic [nstc_pkg::SPAN_ID_W-1:0]       req_span_id,
   input  logic [nstc_pkg::TIME_W-1:0]          req_now_ns,
   input  logic [nstc_pkg::READ_INDEX_W-1:0]    req_read_index,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_rd_valid,
   input  logic [nstc_pkg::SPAN_ID_W-1:0]       rsp_rd_span_id,
   input  logic [nstc_pkg::RD_DEPTH_W-1:0]      rsp_rd_depth,
   input  logic [nstc_pkg::TIME_W-1:0]          rsp_rd_start_ns,
   input  logic [nstc_pkg::TIME_W-1:0]          rsp_rd_duration_ns,
   input  logic [nstc_pkg::CAPTURE_COUNT_W-1:0] rsp_capture_count,
   input  logic                                 rsp_overflowed,
   input  logic [nstc_pkg::ACTIVE_DEPTH_W-1:0]  rsp_active_depth,
   input  logic [nstc_pkg::ERROR_W-1:0]         rsp_error_code,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   checked,
   output int                                   full_hits,
   output int                                   empty_hits,
   output int                                   mismatch_hits,
   output int                                   overflow_hits
);

   localparam int STACK_SLOTS = nstc_pkg::STACK_DEPTH_DEF;
   localparam int CAP_SLOTS   = nstc_pkg::CAPTURE_ENTRIES_DEF;

   typedef struct packed {
      logic                                 rd_valid;
      logic [nstc_pkg::SPAN_ID_W-1:0]       rd_span_id;
      logic [nstc_pkg::RD_DEPTH_W-1:0]      rd_depth;
      logic [nstc_pkg::TIME_W-1:0]          rd_start_ns;
      logic [nstc_pkg::TIME_W-1:0]          rd_duration_ns;
      logic [nstc_pkg::CAPTURE_COUNT_W-1:0] capture_count;
      logic                                 overflowed;
      logic [nstc_pkg::ACTIVE_DEPTH_W-1:0]  active_depth;
      nstc_pkg::error_type                  error_code;
   } span_report_type;

   // Shadow of the profiler state.
   logic [nstc_pkg::SPAN_ID_W-1:0]  open_id_stack    [STACK_SLOTS];
   logic [nstc_pkg::TIME_W-1:0]     open_start_stack [STACK_SLOTS];
   int                              open_total;
   logic [nstc_pkg::SPAN_ID_W-1:0]  cap_id    [CAP_SLOTS];
   logic [nstc_pkg::RD_DEPTH_W-1:0] cap_depth [CAP_SLOTS];
   logic [nstc_pkg::TIME_W-1:0]     cap_start [CAP_SLOTS];
   logic [nstc_pkg::TIME_W-1:0]     cap_span  [CAP_SLOTS];
   int                              cap_total;
   logic                            drop_flag;

   span_report_type expected_reports[$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      checked       = 0;
      full_hits     = 0;
      empty_hits    = 0;
      mismatch_hits = 0;
      overflow_hits = 0;
      open_total    = 0;
      cap_total     = 0;
      drop_flag     = 1'b0;
   end

   // Applies one request word to the shadow state and returns the response.
   function automatic span_report_type forecast_word(
      input logic [nstc_pkg::REQ_TYPE_W-1:0]   kind,
      input logic [nstc_pkg::SPAN_ID_W-1:0]    id,
      input logic [nstc_pkg::TIME_W-1:0]       now,
      input logic [nstc_pkg::READ_INDEX_W-1:0] idx
   );
      span_report_type                r;
      logic [nstc_pkg::SPAN_ID_W-1:0] top_id;
      logic [nstc_pkg::TIME_W-1:0]    top_start;
      r = '0;
      r.error_code = nstc_pkg::ERR_NONE;
      case (kind)
         nstc_pkg::REQ_FRAME: begin
            cap_total = 0;
            drop_flag = 1'b0;
         end
         nstc_pkg::REQ_BEGIN: begin
            if (open_total >= STACK_SLOTS) begin
               r.error_code = nstc_pkg::ERR_FULL;
            end else begin
               open_id_stack[open_total]    = id;
               open_start_stack[open_total] = now;
               open_total++;
            end
         end
         nstc_pkg::REQ_END: begin
            if (open_total == 0) begin
               r.error_code = nstc_pkg::ERR_EMPTY;
            end else begin
               open_total--;
               top_id    = open_id_stack[open_total];
               top_start = open_start_stack[open_total];
               if (top_id != id) r.error_code = nstc_pkg::ERR_MISMATCH;
               if (cap_total < CAP_SLOTS) begin
                  cap_id[cap_total]    = top_id;
                  cap_depth[cap_total] = nstc_pkg::RD_DEPTH_W'(open_total);
                  cap_start[cap_total] = top_start;
                  // Time running backwards gives a zero duration.
                  cap_span[cap_total]  = (now >= top_start) ? now - top_start : '0;
                  cap_total++;
               end else begin
                  drop_flag = 1'b1;
               end
            end
         end
         default: begin
            if (int'(idx) < cap_total) begin
               r.rd_valid       = 1'b1;
               r.rd_span_id     = cap_id[idx];
               r.rd_depth       = cap_depth[idx];
               r.rd_start_ns    = cap_start[idx];
               r.rd_duration_ns = cap_span[idx];
            end
         end
      endcase
      r.capture_count = nstc_pkg::CAPTURE_COUNT_W'(cap_total);
      r.overflowed    = drop_flag;
      r.active_depth  = nstc_pkg::ACTIVE_DEPTH_W'(open_total);
      return r;
   endfunction

   function automatic void compare_field(input string field,
                                         input logic [nstc_pkg::TIME_W-1:0] want_v,
                                         input logic [nstc_pkg::TIME_W-1:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         if (fail_count <= 10)
            $display("Mismatch in %s of response %0d: expected %h, got %h",
                     field, checked, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      span_report_type want;
      if (reset) begin
         open_total = 0;
         cap_total  = 0;
         drop_flag  = 1'b0;
         expected_reports.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_reports.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("Response word with nothing outstanding");
            end else begin
               want = expected_reports.pop_front();
               compare_field("rd_valid", want.rd_valid, rsp_rd_valid);
               compare_field("rd_span_id", want.rd_span_id, rsp_rd_span_id);
               compare_field("rd_depth", want.rd_depth, rsp_rd_depth);
               compare_field("rd_start_ns", want.rd_start_ns, rsp_rd_start_ns);
               compare_field("rd_duration_ns", want.rd_duration_ns, rsp_rd_duration_ns);
               compare_field("capture_count", want.capture_count, rsp_capture_count);
               compare_field("overflowed", want.overflowed, rsp_overflowed);
               compare_field("active_depth", want.active_depth, rsp_active_depth);
               compare_field("error_code", want.error_code, rsp_error_code);
               checked++;
               if (want.error_code == nstc_pkg::ERR_FULL) full_hits++;
               if (want.error_code == nstc_pkg::ERR_EMPTY) empty_hits++;
               if (want.error_code == nstc_pkg::ERR_MISMATCH) mismatch_hits++;
               if (want.overflowed) overflow_hits++;
            end
         end
         if (start && !busy)
            expected_reports.push_back(forecast_word(req_type, req_span_id,
                                                     req_now_ns, req_read_index));
      end
      pending <= expected_reports.size();
   end

endmodule

// ----- dv/tb_nested_span_timer_capture_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Span profiler testbench
// Drives frame, begin, end and read words into the span profiler, mostly as
// properly nested span sequences with drifting timestamps, and lets the
// capture monitor check every response word.
// ---------------------------------------------------------------------------
module tb_nested_span_timer_capture_top;

   // Default sizes of the block, mirrored for stimulus shaping.
   localparam int STACK_SLOTS = nstc_pkg::STACK_DEPTH_DEF;
   localparam int CAP_SLOTS   = nstc_pkg::CAPTURE_ENTRIES_DEF;
   localparam int RANDOM_WORDS = 1800;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [nstc_pkg::REQ_TYPE_W-1:0]      req_type;
   logic [nstc_pkg::SPAN_ID_W-1:0]       req_span_id;
   logic [nstc_pkg::TIME_W-1:0]          req_now_ns;
   logic [nstc_pkg::READ_INDEX_W-1:0]    req_read_index;
   logic                                 rsp_valid;
   logic                                 rsp_rd_valid;
   logic [nstc_pkg::SPAN_ID_W-1:0]       rsp_rd_span_id;
   logic [nstc_pkg::RD_DEPTH_W-1:0]      rsp_rd_depth;
   logic [nstc_pkg::TIME_W-1:0]          rsp_rd_start_ns;
   logic [nstc_pkg::TIME_W-1:0]          rsp_rd_duration_ns;
   logic [nstc_pkg::CAPTURE_COUNT_W-1:0] rsp_capture_count;
   logic                                 rsp_overflowed;
   logic [nstc_pkg::ACTIVE_DEPTH_W-1:0]  rsp_active_depth;
   logic [nstc_pkg::ERROR_W-1:0]         rsp_error_code;

   int fail_count;
   int pending;
   int checked;
   int full_hits;
   int empty_hits;
   int mismatch_hits;
   int overflow_hits;

   // The stimulus keeps a light shadow of the stack ids and the capture count
   // so that it can close spans with the right id and read valid indexes.
   logic [nstc_pkg::SPAN_ID_W-1:0] open_ids[$];
   int                             cap_shadow;
   int                             dropped_ends;
   int                             words_sent;
   logic [nstc_pkg::TIME_W-1:0]    clock_ns;

   nested_span_timer_capture_top u_top (.*);

   nstc_capture_monitor u_monitor (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sends one word: the fields change on the falling edge, and the word is
   // taken at the first rising edge where busy is low. Start stays high from
   // one word to the next, so back to back words need no extra assignment.
   task automatic send_word(input logic [nstc_pkg::REQ_TYPE_W-1:0] kind,
                            input logic [nstc_pkg::SPAN_ID_W-1:0] id,
                            input logic [nstc_pkg::TIME_W-1:0] now,
                            input logic [nstc_pkg::READ_INDEX_W-1:0] idx);
      @(negedge clock);
      start          <= 1'b1;
      req_type       <= kind;
      req_span_id    <= id;
      req_now_ns     <= now;
      req_read_index <= idx;
      do @(posedge clock); while (busy);
      words_sent++;
      case (kind)
         nstc_pkg::REQ_FRAME: cap_shadow = 0;
         nstc_pkg::REQ_BEGIN: if (open_ids.size() < STACK_SLOTS) open_ids.push_back(id);
         nstc_pkg::REQ_END: begin
            if (open_ids.size() > 0) begin
               void'(open_ids.pop_back());
               if (cap_shadow < CAP_SLOTS) cap_shadow++;
               else dropped_ends++;
            end
         end
         default: ;
      endcase
   endtask

   // Holds start low for the given number of cycles.
   task automatic pause_words(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Moves the time source on. Mostly it creeps forward, but now and then it
   // steps backwards or jumps to an arbitrary 64-bit value, which exercises
   // the zero clamp on durations and every bit of the timestamp.
   task automatic advance_clock();
      int roll;
      roll = $urandom_range(99);
      if (roll < 3) clock_ns = {$urandom, $urandom};
      else if (roll < 7) clock_ns = clock_ns - $urandom_range(1, 5000);
      else clock_ns = clock_ns + $urandom_range(0, 2000);
   endtask

   // Picks and sends one word. Most words follow the nesting discipline:
   // begins and ends balance, ends name the span on top, and reads ask for an
   // index that holds a capture. A small share is plain noise, which holds no
   // frame start while the capture memory is being filled.
   task automatic send_span_word(input bit reads_ok, input bit frames_ok);
      logic [nstc_pkg::REQ_TYPE_W-1:0]   kind;
      logic [nstc_pkg::SPAN_ID_W-1:0]    id;
      logic [nstc_pkg::READ_INDEX_W-1:0] idx;
      int                                roll;
      int                                depth;
      advance_clock();
      roll  = $urandom_range(99);
      depth = open_ids.size();
      id    = nstc_pkg::SPAN_ID_W'($urandom);
      idx   = nstc_pkg::READ_INDEX_W'($urandom);
      if ($urandom_range(99) < 8) begin
         kind = nstc_pkg::REQ_TYPE_W'($urandom);
         if (!frames_ok && kind == nstc_pkg::REQ_FRAME) kind = nstc_pkg::REQ_READ;
      end else if (reads_ok && roll < 12) begin
         kind = nstc_pkg::REQ_READ;
         if (cap_shadow > 0 && $urandom_range(99) < 80)
            idx = nstc_pkg::READ_INDEX_W'($urandom_range(0, cap_shadow - 1));
      end else if (depth == 0 || (depth < STACK_SLOTS && roll < 56)) begin
         kind = nstc_pkg::REQ_BEGIN;
      end else if (depth == STACK_SLOTS && roll < 20) begin
         // A begin on a full stack must be refused and flagged.
         kind = nstc_pkg::REQ_BEGIN;
      end else begin
         kind = nstc_pkg::REQ_END;
         // One end in ten names a random span id; the top is popped anyway.
         if ($urandom_range(99) < 90) id = open_ids[depth - 1];
      end
      send_word(kind, id, clock_ns, idx);
   endtask

   // Random gaps between words, except in one long quiet stretch where the
   // words arrive back to back and the request queue fills up.
   task automatic maybe_pause();
      if ((words_sent < 700 || words_sent > 1100) && $urandom_range(99) < 7)
         pause_words(1);
   endtask

   initial begin
      int episode_len;
      int episode;
      reset          = 1'b1;
      start          = 1'b0;
      req_type       = nstc_pkg::REQ_FRAME;
      req_span_id    = '0;
      req_now_ns     = '0;
      req_read_index = '0;
      cap_shadow     = 0;
      dropped_ends   = 0;
      words_sent     = 0;
      clock_ns       = 64'd1000;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. An end with nothing open and a read with nothing
      // captured come first; then the stack is filled to the brim, with the
      // outermost span starting at the top of the time range.
      send_word(nstc_pkg::REQ_FRAME, '0, '0, '0);
      send_word(nstc_pkg::REQ_END, 5'd7, 64'd10, '0);
      send_word(nstc_pkg::REQ_READ, '0, 64'd10, 8'd255);
      send_word(nstc_pkg::REQ_BEGIN, 5'd31, '1, '0);
      for (int i = 0; i < STACK_SLOTS - 1; i++)
         send_word(nstc_pkg::REQ_BEGIN, nstc_pkg::SPAN_ID_W'(i), '0, '0);
      // The stack is full now, so this begin must be refused.
      send_word(nstc_pkg::REQ_BEGIN, 5'd9, 64'd5, '0);
      // Matching end at the top of the time range gives the largest duration.
      send_word(nstc_pkg::REQ_END, 5'd14, '1, '0);
      // The top span is 13, so this end is a mismatch; it is still recorded.
      send_word(nstc_pkg::REQ_END, 5'd0, 64'd3, '0);
      send_word(nstc_pkg::REQ_READ, '0, '0, 8'd0);
      send_word(nstc_pkg::REQ_READ, '0, '0, 8'd1);
      send_word(nstc_pkg::REQ_READ, '0, '0, 8'd2);

      // Random part, in episodes. Most episodes open with a frame start; the
      // second one never does and runs until the capture memory has filled
      // and a few dozen further spans have been dropped.
      episode = 0;
      while (words_sent < RANDOM_WORDS + 25) begin
         if (episode == 1) begin
            while (dropped_ends < 40) begin
               send_span_word(cap_shadow >= CAP_SLOTS - 8, 1'b0);
               maybe_pause();
            end
            for (int i = 0; i < 12; i++) begin
               send_word(nstc_pkg::REQ_READ, '0, clock_ns,
                         (i < 4) ? nstc_pkg::READ_INDEX_W'(CAP_SLOTS - 1 - i)
                                 : nstc_pkg::READ_INDEX_W'($urandom));
               maybe_pause();
            end
         end else begin
            if ($urandom_range(99) < 60)
               send_word(nstc_pkg::REQ_FRAME, nstc_pkg::SPAN_ID_W'($urandom), clock_ns,
                         nstc_pkg::READ_INDEX_W'($urandom));
            episode_len = $urandom_range(20, 150);
            repeat (episode_len) begin
               send_span_word(1'b1, 1'b1);
               maybe_pause();
            end
         end
         episode++;
      end
      pause_words(1);

      // Drain: wait until every response has arrived, then keep the clock running
      // so that a stray extra response would still be caught.
      do @(negedge clock); while (pending != 0);
      repeat (10) @(posedge clock);

      $display("Drove %0d request words over %0d episodes; %0d responses checked.",
               words_sent, episode, checked);
      $display("Responses included %0d stack-full, %0d stack-empty, %0d id-mismatch, %0d %s",
               full_hits, empty_hits, mismatch_hits, overflow_hits, "with the overflow flag set.");
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
